@@ hdl/shbis_pkg.sv @@
// ----------------------------------------------------------------------------
// shbis_pkg
// Shared types, constants and the (13,8) SECDED encode function for the
// interleaved Hamming bit source.
// ----------------------------------------------------------------------------
package shbis_pkg;

  localparam int unsigned GroupBytes = 4;   // bytes per interleaved group, 1..4
  localparam int unsigned DataBits   = 8;
  localparam int unsigned CodeBits   = 13;
  localparam int unsigned TotalBits  = GroupBytes * CodeBits;
  localparam int unsigned CntW       = (GroupBytes > 1) ? $clog2(GroupBytes) : 1;
  localparam int unsigned BitCntW    = $clog2(TotalBits);
  localparam int unsigned QDepth     = 2;   // groups in flight between front and back
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  typedef logic [CodeBits-1:0]                   codeword_t;
  typedef logic [GroupBytes-1:0][CodeBits-1:0]   group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Bit k of the result holds codeword position k+1.
  function automatic codeword_t encode_byte(input logic [DataBits-1:0] d);
    codeword_t w;
    w      = '0;
    w[2]   = d[0];
    w[4]   = d[1];
    w[5]   = d[2];
    w[6]   = d[3];
    w[8]   = d[4];
    w[9]   = d[5];
    w[10]  = d[6];
    w[11]  = d[7];
    w[0]   = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
    w[1]   = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
    w[3]   = d[1] ^ d[2] ^ d[3] ^ d[7];
    w[7]   = d[4] ^ d[5] ^ d[6] ^ d[7];
    w[12]  = ^w[11:0];
    return w;
  endfunction

endpackage

@@ hdl/shbis_front.sv @@
// ----------------------------------------------------------------------------
// shbis_front
// Accepts bytes, applies the sticky end-of-data flag, encodes each byte and
// collects a group of codewords, which it pushes into the group queue.
// ----------------------------------------------------------------------------
module shbis_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  data_byte_i,
  input  logic                        data_ended_i,
  input  shbis_pkg::q_status_t        q_status_i,
  output logic                        q_push_o,
  output shbis_pkg::group_t           q_group_o
);

  logic [shbis_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                       ended_q, ended_d;
  shbis_pkg::group_t          cw_q;
  shbis_pkg::codeword_t       cw_new;
  logic                       last_slot;
  logic                       accept;
  logic [7:0]                 value;

  assign last_slot = (cnt_q == shbis_pkg::CntW'(shbis_pkg::GroupBytes - 1));
  // only the group-closing byte has to wait for queue space
  assign full      = last_slot && q_status_i.full;
  assign accept    = push && !full;

  assign ended_d = ended_q | data_ended_i;
  assign value   = ended_d ? 8'h00 : data_byte_i;
  assign cw_new  = shbis_pkg::encode_byte(value);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last_slot ? '0 : cnt_q + shbis_pkg::CntW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < shbis_pkg::GroupBytes; i++) begin
      q_group_o[i] = cw_q[i];
    end
    q_group_o[shbis_pkg::GroupBytes-1] = cw_new;
  end

  assign q_push_o = accept && last_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ended_q <= 1'b0;
    end else if (accept) begin
      cnt_q   <= cnt_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !last_slot) begin
      cw_q[cnt_q] <= cw_new;
    end
  end

endmodule

@@ hdl/shbis_fifo.sv @@
// ----------------------------------------------------------------------------
// shbis_fifo
// Short queue of complete codeword groups between the front and back parts.
// ----------------------------------------------------------------------------
module shbis_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  shbis_pkg::group_t      wdata_i,
  input  logic                   pop_i,
  output shbis_pkg::group_t      rdata_o,
  output shbis_pkg::q_status_t   status_o
);

  shbis_pkg::group_t              mem [shbis_pkg::QDepth];
  logic [shbis_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [shbis_pkg::QCntW-1:0]    cnt_q;
  logic                           do_push, do_pop;

  assign status_o.full  = (cnt_q == shbis_pkg::QCntW'(shbis_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + shbis_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + shbis_pkg::QPtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + shbis_pkg::QCntW'(1);
        2'b01:   cnt_q <= cnt_q - shbis_pkg::QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/shbis_back.sv @@
// ----------------------------------------------------------------------------
// shbis_back
// Serializer: loads a group from the queue in interleaved order and shifts
// out one codeword bit per transaction, marking the final bit of the group.
// ----------------------------------------------------------------------------
module shbis_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  shbis_pkg::q_status_t   q_status_i,
  input  shbis_pkg::group_t      q_group_i,
  output logic                   q_pop_o,
  output logic                   empty,
  input  logic                   pop,
  output logic                   code_bit_o,
  output logic                   group_last_o
);

  localparam logic [shbis_pkg::BitCntW-1:0] LastIdx =
    shbis_pkg::BitCntW'(shbis_pkg::TotalBits - 1);

  logic [shbis_pkg::TotalBits-1:0] bits_q, bits_ilv;
  logic [shbis_pkg::BitCntW-1:0]   cnt_q;
  logic                            busy_q;
  logic                            last;
  logic                            take;
  logic                            load;

  // emission order: codeword bit j of every byte before bit j+1
  always_comb begin
    for (int j = 0; j < shbis_pkg::CodeBits; j++) begin
      for (int i = 0; i < shbis_pkg::GroupBytes; i++) begin
        bits_ilv[j*shbis_pkg::GroupBytes + i] = q_group_i[i][j];
      end
    end
  end

  assign last         = (cnt_q == LastIdx);
  assign take         = pop && busy_q;
  assign load         = !q_status_i.empty && (!busy_q || (take && last));
  assign q_pop_o      = load;
  assign empty        = !busy_q;
  assign code_bit_o   = bits_q[0];
  assign group_last_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (take) begin
      if (last) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cnt_q  <= cnt_q + shbis_pkg::BitCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q <= bits_ilv;
    end else if (take) begin
      bits_q <= bits_q >> 1;
    end
  end

endmodule

@@ hdl/secded_hamming_interleaved_bit_source_top.sv @@
// ----------------------------------------------------------------------------
// secded_hamming_interleaved_bit_source_top
// Extended Hamming (13,8) SECDED encoder with interleaved serial bit output.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle while full is low and are encoded as 13-bit SECDED
// codewords; each group of four bytes is queued (two groups deep) and shifted
// out as 52 interleaved bits, one bit per cycle while pop is held, codeword
// bit j of bytes 0..3 for j from 0 to 12, with group_last_o set on the final
// bit. The serializer sets the sustained rate. With it idle, the first bit of
// a group is available once the group has gone through the queue into its
// shift register, and groups follow without a gap while the next is queued.
// Once data_ended_i is seen, that byte and all later ones are encoded as zero.
// full rises only for a group-closing byte while both queue slots are taken.
module secded_hamming_interleaved_bit_source_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       data_ended_i,
  output logic       empty,
  input  logic       pop,
  output logic       code_bit_o,
  output logic       group_last_o
);

  shbis_pkg::q_status_t q_status;
  shbis_pkg::group_t    q_wdata, q_rdata;
  logic                 q_push, q_pop;

  shbis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .data_ended_i (data_ended_i),
    .q_status_i   (q_status),
    .q_push_o     (q_push),
    .q_group_o    (q_wdata)
  );

  shbis_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wdata_i  (q_wdata),
    .pop_i    (q_pop),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  shbis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .q_group_i    (q_rdata),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .code_bit_o   (code_bit_o),
    .group_last_o (group_last_o)
  );

`ifndef SYNTH
  a_no_q_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("group pushed into full queue");

  a_no_q_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("group popped from empty queue");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && group_last_o && q_status.empty) |=> empty)
    else $error("output still shown after final bit with no queued group");

  a_next_group_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && group_last_o && !q_status.empty) |=> (!empty && !group_last_o))
    else $error("queued group not loaded right after final bit");
`endif

endmodule
